[sv/dttn_pkg.sv]
// Shared constants and types for the decimal text to number parser.
package dttn_pkg;

  localparam int unsigned MAG_BITS_DEF = 63;
  localparam int unsigned CH_W         = 8;
  localparam int unsigned FRAC_W       = 6;
  localparam int unsigned MANT_W       = 64;
  localparam int unsigned DIGIT_W      = 4;

  localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CH_W-1:0] CH_NINE  = 8'd57;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CH_W-1:0] CH_POINT = 8'd46;

  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_MALFORMED = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    logic [FRAC_W-1:0] frac_count;
    logic              point_seen;
    logic              sign_used;
    logic              negative;
    logic              at_start;
    logic              ended;
    logic              malformed;
    logic              overflowed;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{
    frac_count: '0,
    point_seen: 1'b0,
    sign_used:  1'b0,
    negative:   1'b0,
    at_start:   1'b1,
    ended:      1'b0,
    malformed:  1'b0,
    overflowed: 1'b0
  };

endpackage

[sv/dttn_step.sv]
// Per-character parse step: next parser state and the result of a final beat.
module dttn_step #(
  parameter int unsigned MAG_BITS = dttn_pkg::MAG_BITS_DEF
) (
  input  logic [dttn_pkg::CH_W-1:0]     ch_i,
  input  logic                          last_i,
  input  logic [MAG_BITS-1:0]           mag_i,
  input  dttn_pkg::flags_t              flags_i,
  output logic [MAG_BITS-1:0]           mag_o,
  output dttn_pkg::flags_t              flags_o,
  output dttn_pkg::status_e             status_o,
  output logic [dttn_pkg::MANT_W-1:0]   mantissa_o,
  output logic [dttn_pkg::FRAC_W-1:0]   frac_digits_o
);

  localparam int unsigned WIDE_W = MAG_BITS + dttn_pkg::DIGIT_W;

  logic [WIDE_W-1:0]                 mag_wide;
  logic [WIDE_W-1:0]                 mag_x10;
  logic [dttn_pkg::DIGIT_W-1:0]      digit;
  logic [dttn_pkg::CH_W-1:0]         ch_off;
  logic                              is_digit;
  logic                              ovf;
  logic [MAG_BITS-1:0]               mag_n;
  dttn_pkg::flags_t                  flags_n;
  logic [dttn_pkg::MANT_W-1:0]       mag_ext;

  assign ch_off   = ch_i - dttn_pkg::CH_ZERO;
  assign digit    = ch_off[dttn_pkg::DIGIT_W-1:0];
  assign is_digit = (ch_i >= dttn_pkg::CH_ZERO) && (ch_i <= dttn_pkg::CH_NINE);
  assign mag_wide = WIDE_W'(mag_i);
  // 10*m + d; overflow when any bit above the magnitude is set, or when frac_count is at FRAC_MAX
  assign mag_x10  = (mag_wide << 3) + (mag_wide << 1) + WIDE_W'(digit);
  assign ovf      = (|mag_x10[WIDE_W-1:MAG_BITS]) ||
                    (flags_i.point_seen && (flags_i.frac_count == dttn_pkg::FRAC_MAX));

  always_comb begin
    mag_n   = mag_i;
    flags_n = flags_i;
    if (!flags_i.ended) begin
      if (ch_i == dttn_pkg::CH_NUL) begin
        flags_n.ended    = 1'b1;
        flags_n.at_start = 1'b0;
      end else begin
        if (is_digit) begin
          if (!flags_i.overflowed) begin
            if (ovf) begin
              flags_n.overflowed = 1'b1;
            end else begin
              mag_n = mag_x10[MAG_BITS-1:0];
              if (flags_i.point_seen) begin
                flags_n.frac_count = flags_i.frac_count + 1'b1;
              end
            end
          end
        end else if (flags_i.at_start &&
                     ((ch_i == dttn_pkg::CH_PLUS) || (ch_i == dttn_pkg::CH_MINUS))) begin
          flags_n.sign_used = 1'b1;
          flags_n.negative  = (ch_i == dttn_pkg::CH_MINUS);
        end else if ((ch_i == dttn_pkg::CH_POINT) && !flags_i.point_seen) begin
          flags_n.point_seen = 1'b1;
        end else begin
          flags_n.malformed = 1'b1;
        end
        flags_n.at_start = 1'b0;
      end
    end
  end

  assign mag_ext = dttn_pkg::MANT_W'(mag_n);

  always_comb begin
    status_o      = dttn_pkg::STAT_OK;
    mantissa_o    = '0;
    frac_digits_o = '0;
    if (flags_n.malformed) begin
      status_o = dttn_pkg::STAT_MALFORMED;
    end else if (flags_n.overflowed) begin
      status_o = dttn_pkg::STAT_OVERFLOW;
    end else begin
      mantissa_o    = flags_n.negative ? (dttn_pkg::MANT_W'(0) - mag_ext) : mag_ext;
      frac_digits_o = flags_n.frac_count;
    end
  end

  // a final beat returns the parser to its start state
  assign mag_o   = last_i ? '0 : mag_n;
  assign flags_o = last_i ? dttn_pkg::FLAGS_RESET : flags_n;

endmodule

[sv/decimal_text_to_number.sv]
// Top level of the streaming ASCII decimal number parser.
// Takes one character per beat with a last flag and gives one result beat per
// number: status, signed mantissa and fraction digit count, the value being
// mantissa x 10^-frac_digits. A new character is taken every cycle unless
// in_stall_o is high. A result becomes valid once its final character has
// passed the input register and then loaded the result register. The clock is
// set by the per-character step: a MAG_BITS+4 bit shift-and-add for the
// times-ten, its overflow check and the mantissa negate. Input stalls only
// while a finished result is held stalled and the next registered character
// is also final.
module decimal_text_to_number #(
  parameter int unsigned MAG_BITS = dttn_pkg::MAG_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [dttn_pkg::CH_W-1:0]    ch_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic signed [dttn_pkg::MANT_W-1:0] mantissa_o,
  output logic [dttn_pkg::FRAC_W-1:0]  frac_digits_o
);

  logic                          in_vld_q;
  logic [dttn_pkg::CH_W-1:0]     ch_q;
  logic                          last_q;
  logic                          advance;

  logic [MAG_BITS-1:0]           mag_q, mag_d;
  dttn_pkg::flags_t              flags_q, flags_d;

  dttn_pkg::status_e             status_d;
  logic [dttn_pkg::MANT_W-1:0]   mant_d;
  logic [dttn_pkg::FRAC_W-1:0]   frac_d;

  logic                          out_vld_q;
  logic [1:0]                    status_q;
  logic [dttn_pkg::MANT_W-1:0]   mant_q;
  logic [dttn_pkg::FRAC_W-1:0]   frac_q;

  // registered beat may move on unless it needs the result slot and that is blocked
  assign advance    = !last_q || !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  dttn_step #(
    .MAG_BITS(MAG_BITS)
  ) u_step (
    .ch_i          (ch_q),
    .last_i        (last_q),
    .mag_i         (mag_q),
    .flags_i       (flags_q),
    .mag_o         (mag_d),
    .flags_o       (flags_d),
    .status_o      (status_d),
    .mantissa_o    (mant_d),
    .frac_digits_o (frac_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      flags_q <= dttn_pkg::FLAGS_RESET;
    end else if (in_vld_q && advance) begin
      mag_q   <= mag_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_vld_q && advance && last_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q && advance && last_q) begin
      status_q <= status_d;
      mant_q   <= mant_d;
      frac_q   <= frac_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = status_q;
  assign mantissa_o    = mant_q;
  assign frac_digits_o = frac_q;

endmodule
